### rtl/sacl_pkg.sv
// shared types and constants of the set-associative tag store
// no dependencies; used by the front end, back end and top level by scoped names
package sacl_pkg;

  // configuration port geometry
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  // widths of the configuration registers
  localparam int SIB_W  = 3;
  localparam int WCL_W  = 2;
  localparam int BOB_W  = 6;
  localparam int MODE_W = 1;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SET_INDEX_BITS    = 2'd0,
    REG_WAY_COUNT_LOG     = 2'd1,
    REG_BLOCK_OFFSET_BITS = 2'd2,
    REG_REPLACEMENT_MODE  = 2'd3
  } cfg_reg_t;

  // replacement modes
  localparam logic [MODE_W-1:0] MODE_LRU  = 1'b0;
  localparam logic [MODE_W-1:0] MODE_FIFO = 1'b1;

  // back end sequencer states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL
  } back_state_t;

  // control from back end to front end
  typedef struct packed {
    logic pop;
    logic clearing;
  } back_ctl_t;

endpackage

### rtl/sacl_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies
module sacl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/sacl_front.sv
// front end: accepts addresses, splits them into set and tag, stamps them
// and holds them in a two-entry queue for the back end; uses sacl_pkg
module sacl_front #(
  parameter int LOG_SETS   = 6,
  parameter int ADDR_BITS  = 64,
  parameter int STAMP_BITS = 32
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_push,
  output logic                                      in_full,
  input  logic [ADDR_BITS-1:0]                      in_address,
  input  logic [sacl_pkg::SIB_W-1:0]                cfg_set_index_bits,
  input  logic [sacl_pkg::BOB_W-1:0]                cfg_block_offset_bits,
  input  sacl_pkg::back_ctl_t                       back_ctl,
  output logic                                      q_valid,
  output logic [((LOG_SETS > 0) ? LOG_SETS : 1)-1:0] q_set,
  output logic [ADDR_BITS-1:0]                      q_tag,
  output logic [STAMP_BITS-1:0]                     q_stamp
);

  localparam int SET_W = (LOG_SETS > 0) ? LOG_SETS : 1;

  logic                  accept;
  logic [3:0]            sbits;
  logic [ADDR_BITS-1:0]  off_sh;
  logic [SET_W-1:0]      set_mask;
  logic [6:0]            tag_shift;
  logic [SET_W-1:0]      dec_set;
  logic [ADDR_BITS-1:0]  dec_tag;

  logic [STAMP_BITS-1:0] cnt_r, cnt_nxt;

  logic [SET_W-1:0]      qs_set_r   [2];
  logic [ADDR_BITS-1:0]  qs_tag_r   [2];
  logic [STAMP_BITS-1:0] qs_stamp_r [2];
  logic                  wr_ptr_r, wr_ptr_nxt;
  logic                  rd_ptr_r, rd_ptr_nxt;
  logic [1:0]            fill_r, fill_nxt;
  logic                  do_pop;

  // handshake
  assign in_full = (fill_r == 2'd2) || back_ctl.clearing;
  assign accept  = in_push && !in_full;
  assign do_pop  = back_ctl.pop && q_valid;

  // address split
  always_comb begin
    sbits     = ({1'b0, cfg_set_index_bits} > 4'(LOG_SETS)) ? 4'(LOG_SETS)
                                                            : {1'b0, cfg_set_index_bits};
    off_sh    = in_address >> cfg_block_offset_bits;
    set_mask  = ~({SET_W{1'b1}} << sbits);
    dec_set   = off_sh[SET_W-1:0] & set_mask;
    tag_shift = 7'(cfg_block_offset_bits) + 7'(sbits);
    dec_tag   = in_address >> tag_shift;
  end

  // saturating access counter, the new value stamps the request
  always_comb begin
    cnt_nxt = cnt_r;
    if (accept && (cnt_r != {STAMP_BITS{1'b1}})) begin
      cnt_nxt = cnt_r + STAMP_BITS'(1);
    end
  end

  // queue pointers and fill level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (accept) begin
      wr_ptr_nxt = ~wr_ptr_r;
    end
    if (do_pop) begin
      rd_ptr_nxt = ~rd_ptr_r;
    end
    if (accept && !do_pop) begin
      fill_nxt = fill_r + 2'd1;
    end else if (!accept && do_pop) begin
      fill_nxt = fill_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      cnt_r    <= cnt_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // queue payload
  always_ff @(posedge clk) begin
    if (accept) begin
      qs_set_r[wr_ptr_r]   <= dec_set;
      qs_tag_r[wr_ptr_r]   <= dec_tag;
      qs_stamp_r[wr_ptr_r] <= cnt_nxt;
    end
  end

  // queue head
  assign q_valid = (fill_r != 2'd0);
  assign q_set   = qs_set_r[rd_ptr_r];
  assign q_tag   = qs_tag_r[rd_ptr_r];
  assign q_stamp = qs_stamp_r[rd_ptr_r];

endmodule

### rtl/sacl_back.sv
// back end: clears the set memory after reset, then reads a set, compares
// the ways, picks a victim on a miss, writes the set back and queues the hit flag;
// uses sacl_pkg and sacl_ram
module sacl_back #(
  parameter int LOG_SETS   = 6,
  parameter int LOG_WAYS   = 3,
  parameter int ADDR_BITS  = 64,
  parameter int STAMP_BITS = 32
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      q_valid,
  input  logic [((LOG_SETS > 0) ? LOG_SETS : 1)-1:0] q_set,
  input  logic [ADDR_BITS-1:0]                      q_tag,
  input  logic [STAMP_BITS-1:0]                     q_stamp,
  input  logic [sacl_pkg::WCL_W-1:0]                cfg_way_count_log,
  input  logic [sacl_pkg::MODE_W-1:0]               cfg_replacement_mode,
  output sacl_pkg::back_ctl_t                       back_ctl,
  output logic                                      out_empty,
  input  logic                                      out_pop,
  output logic                                      out_hit
);

  localparam int SET_W  = (LOG_SETS > 0) ? LOG_SETS : 1;
  localparam int DEPTH  = 1 << LOG_SETS;
  localparam int NWAYS  = 1 << LOG_WAYS;
  localparam int IDX_W  = (LOG_WAYS > 0) ? LOG_WAYS : 1;
  localparam int WAY_W  = 1 + ADDR_BITS + 2 * STAMP_BITS;
  localparam int ROW_W  = NWAYS * WAY_W;
  localparam int INS_LO = 0;
  localparam int LRU_LO = STAMP_BITS;
  localparam int TAG_LO = 2 * STAMP_BITS;
  localparam int VLD_B  = WAY_W - 1;
  localparam logic [SET_W-1:0] LAST_SET = SET_W'(DEPTH - 1);

  sacl_pkg::back_state_t state_r, state_nxt;
  logic [SET_W-1:0]      clr_r, clr_nxt;

  logic                  ram_we;
  logic [SET_W-1:0]      ram_waddr;
  logic [ROW_W-1:0]      ram_wdata;
  logic                  ram_re;
  logic [ROW_W-1:0]      ram_rdata;

  logic                  is_fifo;
  logic [2:0]            wlog;
  logic [NWAYS-1:0]      inuse;
  logic [NWAYS-1:0]      hit_vec;
  logic [NWAYS-1:0]      free_vec;
  logic                  hit;
  logic                  free_found;
  logic [IDX_W-1:0]      hit_way;
  logic [IDX_W-1:0]      free_way;
  logic [IDX_W-1:0]      victim;
  logic [STAMP_BITS:0]   nkey [1:2*NWAYS-1];
  logic [IDX_W-1:0]      nidx [1:2*NWAYS-1];
  logic [ROW_W-1:0]      new_row;

  logic                  res_q_r [2];
  logic                  res_wr_r, res_wr_nxt;
  logic                  res_rd_r, res_rd_nxt;
  logic [1:0]            res_fill_r, res_fill_nxt;
  logic                  res_full;
  logic                  res_push;
  logic                  res_take;

  // set memory, one row holds every way of a set
  sacl_ram #(
    .WIDTH (ROW_W),
    .DEPTH (DEPTH)
  ) u_set_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (q_set),
    .rdata (ram_rdata)
  );

  // ways in use
  always_comb begin
    is_fifo = (cfg_replacement_mode == sacl_pkg::MODE_FIFO);
    wlog    = ({1'b0, cfg_way_count_log} > 3'(LOG_WAYS)) ? 3'(LOG_WAYS)
                                                         : {1'b0, cfg_way_count_log};
    for (int w = 0; w < NWAYS; w++) begin
      inuse[w] = ((w >> wlog) == 0);
    end
  end

  // tag compare and free way search
  always_comb begin
    for (int w = 0; w < NWAYS; w++) begin
      hit_vec[w]  = inuse[w] && ram_rdata[w*WAY_W + VLD_B]
                    && (ram_rdata[w*WAY_W + TAG_LO +: ADDR_BITS] == q_tag);
      free_vec[w] = inuse[w] && !ram_rdata[w*WAY_W + VLD_B];
    end
    hit        = |hit_vec;
    free_found = |free_vec;
    hit_way    = '0;
    free_way   = '0;
    for (int w = NWAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) begin
        hit_way = IDX_W'(w);
      end
      if (free_vec[w]) begin
        free_way = IDX_W'(w);
      end
    end
  end

  // oldest stamp by a tournament tree, the lower way wins ties,
  // ways not in use never win
  always_comb begin
    for (int w = 0; w < NWAYS; w++) begin
      nkey[NWAYS + w] = {~inuse[w], is_fifo ? ram_rdata[w*WAY_W + INS_LO +: STAMP_BITS]
                                            : ram_rdata[w*WAY_W + LRU_LO +: STAMP_BITS]};
      nidx[NWAYS + w] = IDX_W'(w);
    end
    for (int n = NWAYS - 1; n >= 1; n--) begin
      if (nkey[2*n + 1] < nkey[2*n]) begin
        nkey[n] = nkey[2*n + 1];
        nidx[n] = nidx[2*n + 1];
      end else begin
        nkey[n] = nkey[2*n];
        nidx[n] = nidx[2*n];
      end
    end
    victim = free_found ? free_way : nidx[1];
  end

  // updated row
  always_comb begin
    new_row = ram_rdata;
    for (int w = 0; w < NWAYS; w++) begin
      if (hit) begin
        if ((IDX_W'(w) == hit_way) && !is_fifo) begin
          new_row[w*WAY_W + LRU_LO +: STAMP_BITS] = q_stamp;
        end
      end else if (IDX_W'(w) == victim) begin
        new_row[w*WAY_W + VLD_B]               = 1'b1;
        new_row[w*WAY_W + TAG_LO +: ADDR_BITS] = q_tag;
        if (is_fifo) begin
          new_row[w*WAY_W + INS_LO +: STAMP_BITS] = q_stamp;
        end else begin
          new_row[w*WAY_W + LRU_LO +: STAMP_BITS] = q_stamp;
        end
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    case (state_r)
      sacl_pkg::ST_CLEAR: begin
        clr_nxt = clr_r + SET_W'(1);
        if (clr_r == LAST_SET) begin
          state_nxt = sacl_pkg::ST_IDLE;
        end
      end
      sacl_pkg::ST_IDLE: begin
        if (q_valid) begin
          state_nxt = sacl_pkg::ST_EVAL;
        end
      end
      sacl_pkg::ST_EVAL: begin
        if (!res_full) begin
          state_nxt = sacl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sacl_pkg::ST_CLEAR;
        clr_nxt   = '0;
      end
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    ram_we            = 1'b0;
    ram_waddr         = q_set;
    ram_wdata         = new_row;
    ram_re            = 1'b0;
    res_push          = 1'b0;
    back_ctl.pop      = 1'b0;
    back_ctl.clearing = 1'b0;
    case (state_r)
      sacl_pkg::ST_CLEAR: begin
        back_ctl.clearing = 1'b1;
        ram_we            = 1'b1;
        ram_waddr         = clr_r;
        ram_wdata         = '0;
      end
      sacl_pkg::ST_IDLE: begin
        ram_re = q_valid;
      end
      sacl_pkg::ST_EVAL: begin
        if (!res_full) begin
          ram_we       = 1'b1;
          res_push     = 1'b1;
          back_ctl.pop = 1'b1;
        end
      end
      default: begin
        back_ctl.clearing = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sacl_pkg::ST_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
  end

  // result queue
  assign res_full  = (res_fill_r == 2'd2);
  assign out_empty = (res_fill_r == 2'd0);
  assign res_take  = out_pop && !out_empty;
  assign out_hit   = res_q_r[res_rd_r];

  always_comb begin
    res_wr_nxt   = res_wr_r;
    res_rd_nxt   = res_rd_r;
    res_fill_nxt = res_fill_r;
    if (res_push) begin
      res_wr_nxt = ~res_wr_r;
    end
    if (res_take) begin
      res_rd_nxt = ~res_rd_r;
    end
    if (res_push && !res_take) begin
      res_fill_nxt = res_fill_r + 2'd1;
    end else if (!res_push && res_take) begin
      res_fill_nxt = res_fill_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_wr_r   <= 1'b0;
      res_rd_r   <= 1'b0;
      res_fill_r <= 2'd0;
    end else begin
      res_wr_r   <= res_wr_nxt;
      res_rd_r   <= res_rd_nxt;
      res_fill_r <= res_fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      res_q_r[res_wr_r] <= hit;
    end
  end

endmodule

### rtl/set_assoc_cache_lru_fifo_core.sv
// top level of the set-associative tag store with lru or fifo replacement
// holds the configuration registers; uses sacl_pkg, sacl_front, sacl_back
//
//  channel   ports                                   handshake
//  input     in_push, in_full, in_address            taken on push && !full
//  result    out_empty, out_pop, out_hit             taken on pop && !empty
//  config    cfg_we, cfg_index, cfg_wdata            written on cfg_we
//
// in the back end each request has its set row read in ST_IDLE; ST_EVAL then
// compares the ways, picks the victim and writes the row back.
// after reset the set memory is cleared one row a cycle, all 2^LOG_SETS rows,
// with in_full held high; configuration writes are taken during that time.
// a two-entry queue parts the front end from the back end, and a two-entry
// result queue lets the back end run while out_pop is low.
module set_assoc_cache_lru_fifo_core #(
  parameter int LOG_SETS   = 6,
  parameter int LOG_WAYS   = 3,
  parameter int ADDR_BITS  = 64,
  parameter int STAMP_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  output logic                              in_full,
  input  logic [ADDR_BITS-1:0]              in_address,
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic                              out_hit,
  input  logic                              cfg_we,
  input  logic [sacl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sacl_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int SET_W = (LOG_SETS > 0) ? LOG_SETS : 1;

  logic [sacl_pkg::SIB_W-1:0]  set_index_bits_r;
  logic [sacl_pkg::WCL_W-1:0]  way_count_log_r;
  logic [sacl_pkg::BOB_W-1:0]  block_offset_bits_r;
  logic [sacl_pkg::MODE_W-1:0] replacement_mode_r;

  sacl_pkg::back_ctl_t         back_ctl;
  logic                        q_valid;
  logic [SET_W-1:0]            q_set;
  logic [ADDR_BITS-1:0]        q_tag;
  logic [STAMP_BITS-1:0]       q_stamp;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_index_bits_r    <= '0;
      way_count_log_r     <= '0;
      block_offset_bits_r <= '0;
      replacement_mode_r  <= '0;
    end else if (cfg_we) begin
      case (sacl_pkg::cfg_reg_t'(cfg_index))
        sacl_pkg::REG_SET_INDEX_BITS:    set_index_bits_r    <= cfg_wdata[sacl_pkg::SIB_W-1:0];
        sacl_pkg::REG_WAY_COUNT_LOG:     way_count_log_r     <= cfg_wdata[sacl_pkg::WCL_W-1:0];
        sacl_pkg::REG_BLOCK_OFFSET_BITS: block_offset_bits_r <= cfg_wdata[sacl_pkg::BOB_W-1:0];
        sacl_pkg::REG_REPLACEMENT_MODE:  replacement_mode_r  <= cfg_wdata[sacl_pkg::MODE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // address split, stamping and request queue
  sacl_front #(
    .LOG_SETS   (LOG_SETS),
    .ADDR_BITS  (ADDR_BITS),
    .STAMP_BITS (STAMP_BITS)
  ) u_front (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_push               (in_push),
    .in_full               (in_full),
    .in_address            (in_address),
    .cfg_set_index_bits    (set_index_bits_r),
    .cfg_block_offset_bits (block_offset_bits_r),
    .back_ctl              (back_ctl),
    .q_valid               (q_valid),
    .q_set                 (q_set),
    .q_tag                 (q_tag),
    .q_stamp               (q_stamp)
  );

  // lookup, replacement and result queue
  sacl_back #(
    .LOG_SETS   (LOG_SETS),
    .LOG_WAYS   (LOG_WAYS),
    .ADDR_BITS  (ADDR_BITS),
    .STAMP_BITS (STAMP_BITS)
  ) u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .q_valid              (q_valid),
    .q_set                (q_set),
    .q_tag                (q_tag),
    .q_stamp              (q_stamp),
    .cfg_way_count_log    (way_count_log_r),
    .cfg_replacement_mode (replacement_mode_r),
    .back_ctl             (back_ctl),
    .out_empty            (out_empty),
    .out_pop              (out_pop),
    .out_hit              (out_hit)
  );

endmodule
